>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/core/mce_pkg.sv
// ---------------------------------------------------------------------------
// Morse encoder package
// Shared types, register codes and the character to Morse code table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mce_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DUR_W     = 16;
  localparam int SYM_MAX   = 5;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DOT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd3;

  localparam logic [DUR_W-1:0] DOT_RST  = 16'd800;
  localparam logic [DUR_W-1:0] DASH_RST = 16'd1600;
  localparam logic [DUR_W-1:0] GAP_RST  = 16'd1000;
  localparam logic [DUR_W-1:0] HOLD_RST = 16'd2000;

  // pattern[4] is the first symbol, 1 = dash
  typedef struct packed {
    logic       invalid;
    logic [2:0] len;
    logic [4:0] pattern;
  } desc_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_length;
    logic [DUR_W-1:0] dash_length;
    logic [DUR_W-1:0] gap_length;
    logic [DUR_W-1:0] invalid_hold;
  } cfg_t;

  function automatic desc_t morse_lookup(input logic [5:0] idx);
    desc_t d;
    d.invalid = 1'b0;
    case (idx)
      6'd0:  begin d.len = 3'd2; d.pattern = 5'b01000; end
      6'd1:  begin d.len = 3'd4; d.pattern = 5'b10000; end
      6'd2:  begin d.len = 3'd4; d.pattern = 5'b10100; end
      6'd3:  begin d.len = 3'd3; d.pattern = 5'b10000; end
      6'd4:  begin d.len = 3'd1; d.pattern = 5'b00000; end
      6'd5:  begin d.len = 3'd4; d.pattern = 5'b00100; end
      6'd6:  begin d.len = 3'd3; d.pattern = 5'b11000; end
      6'd7:  begin d.len = 3'd4; d.pattern = 5'b00000; end
      6'd8:  begin d.len = 3'd2; d.pattern = 5'b00000; end
      6'd9:  begin d.len = 3'd4; d.pattern = 5'b01110; end
      6'd10: begin d.len = 3'd3; d.pattern = 5'b10100; end
      6'd11: begin d.len = 3'd4; d.pattern = 5'b01000; end
      6'd12: begin d.len = 3'd2; d.pattern = 5'b11000; end
      6'd13: begin d.len = 3'd2; d.pattern = 5'b10000; end
      6'd14: begin d.len = 3'd3; d.pattern = 5'b11100; end
      6'd15: begin d.len = 3'd4; d.pattern = 5'b01100; end
      6'd16: begin d.len = 3'd4; d.pattern = 5'b11010; end
      6'd17: begin d.len = 3'd3; d.pattern = 5'b01000; end
      6'd18: begin d.len = 3'd3; d.pattern = 5'b00000; end
      6'd19: begin d.len = 3'd1; d.pattern = 5'b10000; end
      6'd20: begin d.len = 3'd3; d.pattern = 5'b00100; end
      6'd21: begin d.len = 3'd4; d.pattern = 5'b00010; end
      6'd22: begin d.len = 3'd3; d.pattern = 5'b01100; end
      6'd23: begin d.len = 3'd4; d.pattern = 5'b10010; end
      6'd24: begin d.len = 3'd4; d.pattern = 5'b10110; end
      6'd25: begin d.len = 3'd4; d.pattern = 5'b11000; end
      6'd26: begin d.len = 3'd5; d.pattern = 5'b11111; end
      6'd27: begin d.len = 3'd5; d.pattern = 5'b01111; end
      6'd28: begin d.len = 3'd5; d.pattern = 5'b00111; end
      6'd29: begin d.len = 3'd5; d.pattern = 5'b00011; end
      6'd30: begin d.len = 3'd5; d.pattern = 5'b00001; end
      6'd31: begin d.len = 3'd5; d.pattern = 5'b00000; end
      6'd32: begin d.len = 3'd5; d.pattern = 5'b10000; end
      6'd33: begin d.len = 3'd5; d.pattern = 5'b11000; end
      6'd34: begin d.len = 3'd5; d.pattern = 5'b11100; end
      6'd35: begin d.len = 3'd5; d.pattern = 5'b11110; end
      default: begin d.invalid = 1'b1; d.len = 3'd1; d.pattern = 5'b00000; end
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/mce_front.sv
// ---------------------------------------------------------------------------
// Morse encoder front end
// Accepts character codes, classifies them and pushes descriptors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mce_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_code,
  input  logic          q_full,
  output logic          push,
  output mce_pkg::desc_t push_desc
);
  import mce_pkg::*;

  logic  held;
  desc_t desc;
  desc_t cls;
  logic [7:0] letter_idx;
  logic [7:0] digit_idx;

  assign push      = held && !q_full;
  assign in_stall  = held && q_full;
  assign push_desc = desc;

  assign letter_idx = char_code - 8'd65;
  assign digit_idx  = char_code - 8'd22;

  always_comb begin
    if (char_code inside {[8'd65:8'd90]}) begin
      cls = morse_lookup(letter_idx[5:0]);
    end else if (char_code inside {[8'd48:8'd57]}) begin
      cls = morse_lookup(digit_idx[5:0]);
    end else begin
      cls = morse_lookup(6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      desc <= cls;
    end
  end

endmodule

>>> rtl/core/mce_queue.sv
// ---------------------------------------------------------------------------
// Morse encoder descriptor queue
// Small FIFO between the front end and the element sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mce_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output mce_pkg::desc_t head
);
  import mce_pkg::*;

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")
  `ASSERT_PROP(a_count_range, count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

>>> rtl/core/mce_back.sv
// ---------------------------------------------------------------------------
// Morse encoder element sequencer
// Expands queued descriptors into tone and gap elements, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mce_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mce_pkg::cfg_t           cfg,
  input  logic                    q_valid,
  input  mce_pkg::desc_t          head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    tone_on,
  output logic                    is_dash,
  output logic [mce_pkg::DUR_W-1:0] duration,
  output logic                    invalid,
  output logic                    last
);
  import mce_pkg::*;

  logic [2:0]       sym;
  logic             in_gap;
  logic             load;
  logic             e_tone;
  logic             e_dash;
  logic [DUR_W-1:0] e_dur;
  logic             e_inv;
  logic             e_last;
  logic [2:0]       bit_sel;

  assign load    = q_valid && (!out_valid || !out_stall);
  assign pop     = load && e_last;
  assign bit_sel = 3'd4 - sym;

  always_comb begin
    e_tone = 1'b0;
    e_dash = 1'b0;
    e_dur  = cfg.gap_length;
    e_inv  = 1'b0;
    e_last = 1'b0;
    if (head.invalid) begin
      e_dur  = cfg.invalid_hold;
      e_inv  = 1'b1;
      e_last = 1'b1;
    end else if (!in_gap) begin
      e_tone = 1'b1;
      e_dash = head.pattern[bit_sel];
      e_dur  = e_dash ? cfg.dash_length : cfg.dot_length;
      e_last = (sym == head.len - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sym       <= '0;
      in_gap    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (e_last) begin
          sym    <= '0;
          in_gap <= 1'b0;
        end else if (in_gap) begin
          in_gap <= 1'b0;
        end else begin
          sym    <= sym + 3'd1;
          in_gap <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tone_on  <= e_tone;
      is_dash  <= e_dash;
      duration <= e_dur;
      invalid  <= e_inv;
      last     <= e_last;
    end
  end

  `ASSERT_PROP(a_sym_range, sym < 3'(SYM_MAX), "symbol index out of range")
  `ASSERT_PROP(a_inv_last, out_valid && invalid |-> last && !tone_on, "invalid not last")
  `ASSERT_PROP(a_gap_clear, (load && in_gap) |=> (!tone_on && !last), "gap element wrong")

endmodule

>>> rtl/core/morse_character_encoder.sv
// ---------------------------------------------------------------------------
// Morse character encoder
// Turns ASCII characters into runs of Morse tone and gap elements.
// ---------------------------------------------------------------------------
// A-Z and 0-9 expand to their International Morse run, with a silent gap
// element between symbols; any other code gives one silent element flagged
// invalid. The front end takes one character per cycle, unless stalled, into
// a four-deep descriptor queue; the sequencer emits one element per cycle
// unless the output stalls. A character of n symbols gives 2n-1 elements
// (1 to 9), an unsupported code one. Registers are written via cfg_write.
`timescale 1ns / 1ps

module morse_character_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mce_pkg::DUR_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        char_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              tone_on,
  output logic                              is_dash,
  output logic [mce_pkg::DUR_W-1:0]         duration,
  output logic                              invalid,
  output logic                              last
);
  import mce_pkg::*;

  cfg_t  cfg;
  desc_t push_desc;
  desc_t head;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_length   <= DOT_RST;
      cfg.dash_length  <= DASH_RST;
      cfg.gap_length   <= GAP_RST;
      cfg.invalid_hold <= HOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DOT:  cfg.dot_length   <= cfg_data;
        REG_DASH: cfg.dash_length  <= cfg_data;
        REG_GAP:  cfg.gap_length   <= cfg_data;
        REG_HOLD: cfg.invalid_hold <= cfg_data;
        default:  ;
      endcase
    end
  end

  mce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  mce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  mce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tone_on   (tone_on),
    .is_dash   (is_dash),
    .duration  (duration),
    .invalid   (invalid),
    .last      (last)
  );

endmodule

>>> tb/tb_morse_character_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Morse character encoder testbench
// Feeds character codes through a randomly idling sender, takes the element
// stream with random stalls, and checks every element against an in-bench
// Morse expansion under several register settings.
// ---------------------------------------------------------------------------

module tb_morse_character_encoder;

  import mce_pkg::*;

  typedef struct packed {
    logic             tone_on;
    logic             is_dash;
    logic [DUR_W-1:0] duration;
    logic             invalid;
    logic             last;
  } element_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           char_code = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 tone_on;
  logic                 is_dash;
  logic [DUR_W-1:0]     duration;
  logic                 invalid;
  logic                 last;

  logic [7:0] char_backlog[$];
  element_t   tone_plan[$];
  cfg_t       shadow_cfg;
  int         chars_queued   = 0;
  int         chars_accepted = 0;
  int         mismatches     = 0;
  int         idle_pct       = 15;

  morse_character_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tone_on   (tone_on),
    .is_dash   (is_dash),
    .duration  (duration),
    .invalid   (invalid),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A-Z then 0-9
  function automatic string morse_of(input int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      26: return "-----";
      27: return ".----";
      28: return "..---";
      29: return "...--";
      30: return "....-";
      31: return ".....";
      32: return "-....";
      33: return "--...";
      34: return "---..";
      default: return "----.";
    endcase
  endfunction

  task automatic plan_char(input logic [7:0] c);
    string    sym;
    element_t e;
    if (c >= "A" && c <= "Z") begin
      sym = morse_of(int'(c) - int'("A"));
    end else if (c >= "0" && c <= "9") begin
      sym = morse_of(26 + int'(c) - int'("0"));
    end else begin
      e = '{1'b0, 1'b0, shadow_cfg.invalid_hold, 1'b1, 1'b1};
      tone_plan.push_back(e);
      return;
    end
    for (int i = 0; i < sym.len(); i++) begin
      if (i > 0) begin
        e = '{1'b0, 1'b0, shadow_cfg.gap_length, 1'b0, 1'b0};
        tone_plan.push_back(e);
      end
      e.tone_on  = 1'b1;
      e.is_dash  = (sym[i] == "-");
      e.duration = e.is_dash ? shadow_cfg.dash_length : shadow_cfg.dot_length;
      e.invalid  = 1'b0;
      e.last     = (i == sym.len() - 1);
      tone_plan.push_back(e);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_char(char_code);
        chars_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (char_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid  <= 1'b1;
          char_code <= char_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // receiver
  always @(posedge clk) begin
    element_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tone_plan.size() == 0) begin
          $error("element with none pending: tone_on %0d duration %0d invalid %0d",
                 tone_on, duration, invalid);
          mismatches++;
        end else begin
          e = tone_plan.pop_front();
          check_field("tone_on", e.tone_on, tone_on);
          check_field("is_dash", e.is_dash, is_dash);
          check_field("duration", e.duration, duration);
          check_field("invalid", e.invalid, invalid);
          check_field("last", e.last, last);
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DOT:  shadow_cfg.dot_length   = val;
      REG_DASH: shadow_cfg.dash_length  = val;
      REG_GAP:  shadow_cfg.gap_length   = val;
      REG_HOLD: shadow_cfg.invalid_hold = val;
      default: ;
    endcase
  endtask

  task automatic end_reg_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    while (chars_accepted != chars_queued || tone_plan.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic queue_char(input logic [7:0] c);
    char_backlog.push_back(c);
    chars_queued++;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'(int'("A") + $urandom_range(25));
    if (r < 70) return 8'(int'("0") + $urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_regs();
    set_reg(REG_DOT,  16'($urandom_range(65535, 1)));
    set_reg(REG_DASH, 16'($urandom_range(65535, 1)));
    set_reg(REG_GAP,  16'($urandom_range(65535)));
    set_reg(REG_HOLD, 16'($urandom_range(65535)));
    set_reg(REG_HOLD + 3'(1 + $urandom_range(3)), 16'($urandom_range(65535)));
    end_reg_writes();
  endtask

  initial begin
    string first_chars;
    shadow_cfg = '{DOT_RST, DASH_RST, GAP_RST, HOLD_RST};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: letters, digits, nine, and codes with no Morse
    first_chars = "AZ09ETQY5";
    for (int i = 0; i < first_chars.len(); i++) queue_char(first_chars[i]);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h7F);
    queue_char("a");
    queue_char("z");
    queue_char("@");
    queue_char("[");
    queue_char("/");
    queue_char(":");
    queue_char(8'h80);
    settle();

    // lowest lengths, zero gap and hold
    set_reg(REG_DOT, 16'd1);
    set_reg(REG_DASH, 16'd1);
    set_reg(REG_GAP, 16'd0);
    set_reg(REG_HOLD, 16'd0);
    set_reg(REG_HOLD + 3'd1, 16'hFFFF);
    end_reg_writes();
    queue_char("9");
    queue_char("K");
    queue_char("q");
    settle();

    // highest lengths
    set_reg(REG_DOT, 16'hFFFF);
    set_reg(REG_DASH, 16'hFFFF);
    set_reg(REG_GAP, 16'hFFFF);
    set_reg(REG_HOLD, 16'hFFFF);
    end_reg_writes();
    queue_char("0");
    queue_char("5");
    queue_char(8'hC3);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      random_regs();
      idle_pct = (ph == 2) ? 0 : 15;
      for (int n = 0; n < 40; n++) queue_char(pick_char());
      settle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
